### hdl/tsgc_pkg.sv
// tsgc_pkg: shared types, codes, constants and helpers for the two-side game clock
// no dependencies; used by the channel interfaces and all modules in hdl

package tsgc_pkg;

  localparam int TIME_BITS   = 34;
  localparam int MS_W        = 34;
  localparam int WIDE_W      = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam int INIT_SEC_W  = 14;
  localparam int INC_SEC_W   = 8;
  localparam int INIT_MS_W   = 24;
  localparam int INC_MS_W    = 18;
  localparam int MS_PER_SEC_W = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [INIT_SEC_W-1:0]   MAX_INIT_SEC = INIT_SEC_W'(180 * 60);
  localparam logic [INC_SEC_W-1:0]    MAX_INC_SEC  = INC_SEC_W'(180);
  localparam logic [MS_PER_SEC_W-1:0] MS_PER_SEC   = MS_PER_SEC_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_SEC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SW  = 2'd2;

  typedef enum logic [2:0] {
    OP_START, OP_TICK, OP_MOVE, OP_PRESS, OP_PAUSE, OP_RESUME, OP_RESIGN, OP_UNDO
  } op_t;

  typedef enum logic [1:0] {
    PH_SETUP, PH_RUNNING, PH_PAUSED, PH_FINISHED
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_MATE, ST_STALE, ST_DRAW, ST_RESIGN, ST_TIMEOUT
  } status_t;

  typedef enum logic [1:0] {
    SC_NONE, SC_WHITE, SC_BLACK
  } side_code_t;

  typedef enum logic [1:0] {
    OC_NONE, OC_MATE, OC_STALE, OC_DRAW
  } outcome_t;

  typedef struct packed {
    logic [INIT_MS_W-1:0] init_ms;
    logic [INC_MS_W-1:0]  inc_ms;
    logic                 untimed;
    logic                 auto_sw;
  } cfg_t;

  typedef struct packed {
    op_t      op;
    logic     side;
    outcome_t outcome;
    logic     can_mate;
    logic     ply_nonzero;
  } item_t;

  typedef struct packed {
    phase_t               phase;
    logic [TIME_BITS-1:0] white_left;
    logic [TIME_BITS-1:0] black_left;
    logic                 owner;
    logic                 press_owed;
    logic                 owed_side;
    status_t              status;
    side_code_t           winner;
  } state_t;

  typedef struct packed {
    logic [MS_W-1:0] white_ms;
    logic [MS_W-1:0] black_ms;
    phase_t          game_state;
    side_code_t      running_side;
    logic            awaiting_press;
    status_t         result_status;
    side_code_t      winner;
  } res_t;

  function automatic logic [INIT_MS_W-1:0] init_ms_of(logic [CFG_DATA_W-1:0] v);
    logic [INIT_SEC_W-1:0] sec;
    sec = v[INIT_SEC_W-1:0];
    if (sec > MAX_INIT_SEC) sec = MAX_INIT_SEC;
    return INIT_MS_W'(sec) * INIT_MS_W'(MS_PER_SEC);
  endfunction

  function automatic logic [INC_MS_W-1:0] inc_ms_of(logic [CFG_DATA_W-1:0] v);
    logic [INC_SEC_W-1:0] sec;
    sec = v[INC_SEC_W-1:0];
    if (sec > MAX_INC_SEC) sec = MAX_INC_SEC;
    return INC_MS_W'(sec) * INC_MS_W'(MS_PER_SEC);
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] t,
                                                   logic [INC_MS_W-1:0] inc);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS + 1)'(inc);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [MS_W-1:0] ms_out(logic [TIME_BITS-1:0] t);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(t);
    if (w > WIDE_W'({MS_W{1'b1}})) return {MS_W{1'b1}};
    return w[MS_W-1:0];
  endfunction

endpackage

### hdl/tsgc_in_if.sv
// tsgc_in_if: event input channel, valid/ready with the event fields
// depends on tsgc_pkg

interface tsgc_in_if import tsgc_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] op;
  logic       side;
  logic [1:0] outcome;
  logic       can_mate;
  logic       ply_nonzero;

  modport source (output valid, op, side, outcome, can_mate, ply_nonzero, input ready);
  modport sink   (input valid, op, side, outcome, can_mate, ply_nonzero, output ready);
endinterface

### hdl/tsgc_out_if.sv
// tsgc_out_if: result channel, valid/ready with both times and game status
// depends on tsgc_pkg

interface tsgc_out_if import tsgc_pkg::*; ();
  logic valid;
  logic ready;
  logic [MS_W-1:0] white_ms;
  logic [MS_W-1:0] black_ms;
  logic [1:0]      game_state;
  logic [1:0]      running_side;
  logic            awaiting_press;
  logic [2:0]      result_status;
  logic [1:0]      winner;

  modport source (output valid, white_ms, black_ms, game_state, running_side,
                  awaiting_press, result_status, winner, input ready);
  modport sink   (input valid, white_ms, black_ms, game_state, running_side,
                  awaiting_press, result_status, winner, output ready);
endinterface

### hdl/tsgc_cfg_if.sv
// tsgc_cfg_if: configuration write channel, valid/ready with register index and data
// depends on tsgc_pkg

interface tsgc_cfg_if import tsgc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/two_side_game_clock.sv
// two_side_game_clock: top level of the two-side game clock with increment
// depends on tsgc_pkg, tsgc_in_if, tsgc_out_if, tsgc_cfg_if and tsgc_step
//
//   channel  direction  transfer when          carries
//   in_ch    sink       valid && ready         one event: op, side, outcome, can_mate, ply_nonzero
//   out_ch   source     valid && ready         state after that event: times, phase, result
//   cfg_ch   sink       valid (ready held 1)   register index and write data
//
// one event per cycle: the game state updates in the cycle of the transfer and the
// result register shows it from the next cycle on
// in_ch.ready is low only while a result waits and out_ch.ready is low
// reset (rst_n low at a clock edge) returns game and config to setup, untimed, no result

module two_side_game_clock import tsgc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tsgc_in_if.sink    in_ch,
  tsgc_out_if.source out_ch,
  tsgc_cfg_if.sink   cfg_ch
);

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  item_t  item;
  res_t   res_r;
  res_t   res_nxt;
  logic   out_valid_r;
  logic   in_xfer;

  localparam state_t STATE_RST = '{
    phase:      PH_SETUP,
    white_left: '0,
    black_left: '0,
    owner:      1'b0,
    press_owed: 1'b0,
    owed_side:  1'b0,
    status:     ST_NONE,
    winner:     SC_NONE
  };

  assign item.op          = op_t'(in_ch.op);
  assign item.side        = in_ch.side;
  assign item.outcome     = outcome_t'(in_ch.outcome);
  assign item.can_mate    = in_ch.can_mate;
  assign item.ply_nonzero = in_ch.ply_nonzero;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  tsgc_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (item),
    .nxt  (state_nxt)
  );

  always_comb begin
    res_nxt.white_ms       = ms_out(state_nxt.white_left);
    res_nxt.black_ms       = ms_out(state_nxt.black_left);
    res_nxt.game_state     = state_nxt.phase;
    res_nxt.running_side   = (state_nxt.phase == PH_RUNNING && !cfg_r.untimed) ?
                             (state_nxt.owner ? SC_BLACK : SC_WHITE) : SC_NONE;
    res_nxt.awaiting_press = state_nxt.press_owed;
    res_nxt.result_status  = state_nxt.status;
    res_nxt.winner         = state_nxt.winner;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_ms <= '0;
      cfg_r.inc_ms  <= '0;
      cfg_r.untimed <= 1'b1;
      cfg_r.auto_sw <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_INIT_SEC: begin
          cfg_r.init_ms <= init_ms_of(cfg_ch.data);
          cfg_r.untimed <= (cfg_ch.data == '0);
        end
        CFG_INC_SEC: cfg_r.inc_ms  <= inc_ms_of(cfg_ch.data);
        CFG_AUTO_SW: cfg_r.auto_sw <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) state_r <= state_nxt;
      if (in_xfer) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.white_ms       = res_r.white_ms;
  assign out_ch.black_ms       = res_r.black_ms;
  assign out_ch.game_state     = res_r.game_state;
  assign out_ch.running_side   = res_r.running_side;
  assign out_ch.awaiting_press = res_r.awaiting_press;
  assign out_ch.result_status  = res_r.result_status;
  assign out_ch.winner         = res_r.winner;

endmodule

### hdl/tsgc_step.sv
// tsgc_step: next game state for one event, pure combinational update
// depends on tsgc_pkg

module tsgc_step import tsgc_pkg::*; (
  input  state_t cur,
  input  cfg_t   cfg,
  input  item_t  item,
  output state_t nxt
);

  logic                 timed;
  logic                 running;
  logic [TIME_BITS-1:0] own_t;
  logic [TIME_BITS-1:0] own_dec;
  logic [TIME_BITS-1:0] own_inc;

  function automatic state_t finish(state_t s, status_t st, side_code_t w);
    state_t r;
    r            = s;
    r.status     = st;
    r.winner     = w;
    r.press_owed = 1'b0;
    r.phase      = PH_FINISHED;
    return r;
  endfunction

  function automatic state_t hand_over(state_t s, logic to, logic tm,
                                       logic [TIME_BITS-1:0] inc_t);
    state_t r;
    r = s;
    if (tm) begin
      if (s.owner) r.black_left = inc_t;
      else r.white_left = inc_t;
    end
    r.owner      = to;
    r.press_owed = 1'b0;
    return r;
  endfunction

  always_comb begin
    timed   = !cfg.untimed;
    running = (cur.phase == PH_RUNNING);
    own_t   = cur.owner ? cur.black_left : cur.white_left;
    own_dec = (own_t != '0) ? own_t - TIME_BITS'(1) : '0;
    own_inc = sat_add(own_t, cfg.inc_ms);
    nxt     = cur;
    unique case (item.op)
      OP_START: begin
        nxt.white_left = TIME_BITS'(cfg.init_ms);
        nxt.black_left = TIME_BITS'(cfg.init_ms);
        nxt.owner      = item.side;
        nxt.press_owed = 1'b0;
        nxt.status     = ST_NONE;
        nxt.winner     = SC_NONE;
        nxt.phase      = PH_RUNNING;
      end
      OP_TICK: begin
        if (running && timed) begin
          if (cur.owner) nxt.black_left = own_dec;
          else nxt.white_left = own_dec;
          if (own_dec == '0) begin
            nxt = finish(nxt, ST_TIMEOUT,
                         item.can_mate ? (cur.owner ? SC_WHITE : SC_BLACK) : SC_NONE);
          end
        end
      end
      OP_MOVE: begin
        if (running) begin
          if (cfg.auto_sw || cfg.untimed) begin
            nxt = hand_over(cur, !item.side, timed, own_inc);
          end else begin
            nxt.press_owed = 1'b1;
            nxt.owed_side  = item.side;
          end
          case (item.outcome)
            OC_MATE:  nxt = finish(nxt, ST_MATE, item.side ? SC_BLACK : SC_WHITE);
            OC_STALE: nxt = finish(nxt, ST_STALE, SC_NONE);
            OC_DRAW:  nxt = finish(nxt, ST_DRAW, SC_NONE);
            default:  ;
          endcase
        end
      end
      OP_PRESS: begin
        if (running && cur.press_owed) nxt = hand_over(cur, !cur.owed_side, timed, own_inc);
      end
      OP_PAUSE: begin
        if (running) nxt.phase = PH_PAUSED;
      end
      OP_RESUME: begin
        if (cur.phase == PH_PAUSED) nxt.phase = PH_RUNNING;
      end
      OP_RESIGN: begin
        if (running || cur.phase == PH_PAUSED) begin
          nxt = finish(cur, ST_RESIGN, item.side ? SC_WHITE : SC_BLACK);
        end
      end
      OP_UNDO: begin
        if (cur.phase != PH_SETUP && item.ply_nonzero) begin
          if (cur.phase == PH_FINISHED) begin
            nxt.status = ST_NONE;
            nxt.winner = SC_NONE;
            nxt.phase  = PH_RUNNING;
          end
          nxt.press_owed = 1'b0;
          nxt.owner      = item.side;
        end
      end
      default: ;
    endcase
  end

endmodule
